// ===== rtl/core/ebb_pkg.sv =====
// ----------------------------------------------------------------------------
// ebb_pkg
// shared types and constants of the edge aware 3x3 box blur
// ----------------------------------------------------------------------------
package ebb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int CFG_DATA_W     = 16;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int ROW_W          = FRAME_HEIGHT_W + 1;
    localparam int CSUM_W         = 10;
    localparam int SUM_W          = 12;
    localparam int NCNT_W         = 4;
    localparam int RECIP_W        = 17;
    localparam int RECIP_SHIFT    = 16;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic [RECIP_W-1:0] RECIP_ONE   = 17'd65536;
    localparam logic [RECIP_W-1:0] RECIP_THREE = 17'd21846;
    localparam logic [RECIP_W-1:0] RECIP_NINE  = 17'd7282;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blur_red;
        logic [7:0] blur_green;
        logic [7:0] blur_blue;
        logic       end_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // row0 is the newest line, row2 the oldest
    typedef struct packed {
        t_pix row0;
        t_pix row1;
        t_pix row2;
    } t_pix_col;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_pair;

    // which neighbors of the result pixel lie inside the frame
    typedef struct packed {
        logic up;
        logic dn;
        logic lf;
        logic rt;
    } t_nbr;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_csum;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sum;

endpackage

// ===== rtl/core/ebb_line_mem.sv =====
// ----------------------------------------------------------------------------
// ebb_line_mem
// two line stores packed into one memory, registered read with write forwarding
// ----------------------------------------------------------------------------
module ebb_line_mem #(
    parameter int DEPTH = ebb_pkg::MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  ebb_pkg::t_line_pair i_wr_data,
    input  logic [AW-1:0]       i_rd_addr,
    output ebb_pkg::t_line_pair o_rd_data
);

    ebb_pkg::t_line_pair r_mem [DEPTH];
    ebb_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ebb_win_cell.sv =====
// ----------------------------------------------------------------------------
// ebb_win_cell
// one window column: holds three pixels, hands them on, gives masked column sums
// ----------------------------------------------------------------------------
module ebb_win_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  ebb_pkg::t_pix_col i_col,
    input  logic              i_use,
    input  ebb_pkg::t_nbr     i_nbr,
    output ebb_pkg::t_pix_col o_col,
    output ebb_pkg::t_csum    o_sum
);

    localparam int CW = ebb_pkg::CSUM_W;

    ebb_pkg::t_pix_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        o_sum = '0;
        if (i_use) begin
            o_sum.red   = CW'(r_col.row1.red)
                        + (i_nbr.dn ? CW'(r_col.row0.red) : '0)
                        + (i_nbr.up ? CW'(r_col.row2.red) : '0);
            o_sum.green = CW'(r_col.row1.green)
                        + (i_nbr.dn ? CW'(r_col.row0.green) : '0)
                        + (i_nbr.up ? CW'(r_col.row2.green) : '0);
            o_sum.blue  = CW'(r_col.row1.blue)
                        + (i_nbr.dn ? CW'(r_col.row0.blue) : '0)
                        + (i_nbr.up ? CW'(r_col.row2.blue) : '0);
        end
    end

    assign o_col = r_col;

endmodule

// ===== rtl/core/ebb_mean.sv =====
// ----------------------------------------------------------------------------
// ebb_mean
// rounded mean of one channel over 1, 2, 3, 4, 6 or 9 pixels by reciprocal
// ----------------------------------------------------------------------------
module ebb_mean (
    input  logic [ebb_pkg::SUM_W-1:0]  i_sum,
    input  logic [ebb_pkg::NCNT_W-1:0] i_n,
    output logic [7:0]                 o_mean
);

    localparam int SW = ebb_pkg::SUM_W;
    localparam int PW = ebb_pkg::SUM_W + ebb_pkg::RECIP_W;

    logic [SW-1:0]                y;
    logic [SW-1:0]                a;
    logic [ebb_pkg::RECIP_W-1:0]  m;
    logic [PW-1:0]                prod;

    // half of n added first, so the quotient rounds half up
    assign y = i_sum + SW'(i_n >> 1);

    always_comb begin
        a = y;
        m = ebb_pkg::RECIP_ONE;
        case (i_n)
            4'd2: begin
                a = y >> 1;
            end
            4'd3: begin
                m = ebb_pkg::RECIP_THREE;
            end
            4'd4: begin
                a = y >> 2;
            end
            4'd6: begin
                a = y >> 1;
                m = ebb_pkg::RECIP_THREE;
            end
            4'd9: begin
                m = ebb_pkg::RECIP_NINE;
            end
            default: begin
                a = y;
            end
        endcase
    end

    assign prod   = PW'(a) * PW'(m);
    assign o_mean = prod[ebb_pkg::RECIP_SHIFT +: 8];

endmodule

// ===== rtl/core/edge_aware_box_blur_3x3_top.sv =====
// ----------------------------------------------------------------------------
// edge_aware_box_blur_3x3_top
// streaming 3x3 rgb box blur with frame edge handling
//
// Takes one item per clock, sustained, as long as results are taken. Pixels
// come in raster order; each result is the per channel rounded mean of the
// in-frame pixels around one pixel. The result for pixel q is started by the
// item numbered q+width+1 of the frame and then passes three register stages
// (window column sums, total and neighbor count, divide by reciprocal).
// After the last pixel, width+1 flush items drain the frame. The two line
// stores share one memory with one write and one read port per cycle, read
// one column ahead. Frame size is taken at the first pixel of each frame.
// ----------------------------------------------------------------------------
module edge_aware_box_blur_3x3_top #(
    parameter int MAX_WIDTH = ebb_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ebb_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ebb_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  ebb_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [ebb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = ebb_pkg::ROW_W;
    localparam int HW    = ebb_pkg::FRAME_HEIGHT_W;
    localparam int SW    = ebb_pkg::SUM_W;
    localparam int NW    = ebb_pkg::NCNT_W;

    // configuration
    logic [ebb_pkg::FRAME_WIDTH_W-1:0] r_cfg_w;
    logic [HW-1:0]                     r_cfg_h;

    // frame position
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [HW-1:0]    r_out_row, n_out_row;
    logic [WID_W-1:0] r_cur_w, n_cur_w;
    logic [HW-1:0]    r_cur_h, n_cur_h;

    // pipeline
    logic               r_s1_valid;
    ebb_pkg::t_nbr      r_s1_nbr;
    logic               r_s1_eof;
    logic               r_s2_valid;
    ebb_pkg::t_sum      r_s2_sum;
    logic [NW-1:0]      r_s2_n;
    logic               r_s2_eof;
    logic               r_out_valid;
    ebb_pkg::t_out_item r_out_data;

    logic               idle;
    logic [WID_W-1:0]   eff_w;
    logic [HW-1:0]      eff_h;
    logic               in_fire;
    logic               is_flush;
    logic               row_in_frame;
    logic               do_push;
    logic               emit;
    logic               col_last;
    ebb_pkg::t_nbr      nbr_now;
    logic               eof_now;
    logic               out_take;
    logic               s2_free;
    logic               s1_free;
    ebb_pkg::t_pix      px;
    ebb_pkg::t_line_pair rd_pair;
    ebb_pkg::t_line_pair wr_pair;
    ebb_pkg::t_pix_col  cell_in  [3];
    ebb_pkg::t_pix_col  cell_out [3];
    ebb_pkg::t_csum     cell_sum [3];
    logic [2:0]         cell_use;
    ebb_pkg::t_sum      tot_sum;
    logic [1:0]         n_rows;
    logic [1:0]         n_cols;
    logic [NW-1:0]      n_cnt;
    logic [7:0]         mean_r;
    logic [7:0]         mean_g;
    logic [7:0]         mean_b;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= ebb_pkg::FRAME_WIDTH_RST;
            r_cfg_h <= ebb_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ebb_pkg::CFG_FRAME_WIDTH: begin
                    r_cfg_w <= i_cfg_data[ebb_pkg::FRAME_WIDTH_W-1:0];
                end
                ebb_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg_h <= i_cfg_data[HW-1:0];
                end
                default: begin
                    r_cfg_w <= r_cfg_w;
                end
            endcase
        end
    end

    // handshake
    assign out_take   = !r_out_valid || i_out_ready;
    assign s2_free    = !r_s2_valid || out_take;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // frame size in effect
    assign idle = (r_in_row == '0) && (r_in_col == '0);

    always_comb begin
        eff_w = r_cur_w;
        eff_h = r_cur_h;
        if (idle) begin
            if (r_cfg_w == '0) begin
                eff_w = WID_W'(1);
            end else if (32'(r_cfg_w) > MAX_WIDTH) begin
                eff_w = WID_W'(MAX_WIDTH);
            end else begin
                eff_w = WID_W'(r_cfg_w);
            end
            eff_h = (r_cfg_h == '0) ? HW'(1) : r_cfg_h;
        end
    end

    assign is_flush     = (i_in_data.func == ebb_pkg::FUNC_FLUSH);
    assign row_in_frame = r_in_row < ROW_W'(eff_h);
    assign do_push      = in_fire && (is_flush ? (!idle && !row_in_frame) : row_in_frame);
    assign emit         = do_push && (r_in_row != '0)
                        && !((r_in_row == ROW_W'(1)) && (r_in_col == '0));
    assign col_last     = (WID_W'(r_in_col) + WID_W'(1)) == eff_w;

    assign nbr_now.up = (r_out_row != '0);
    assign nbr_now.dn = (ROW_W'(r_out_row) + ROW_W'(1)) < ROW_W'(r_cur_h);
    assign nbr_now.lf = (r_out_col != '0);
    assign nbr_now.rt = (WID_W'(r_out_col) + WID_W'(1)) < r_cur_w;
    assign eof_now    = !nbr_now.dn && !nbr_now.rt;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_cur_w   = r_cur_w;
        n_cur_h   = r_cur_h;
        if (do_push) begin
            n_cur_w = eff_w;
            n_cur_h = eff_h;
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
        if (emit) begin
            if (eof_now) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (!nbr_now.rt) begin
                n_out_col = '0;
                n_out_row = r_out_row + HW'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cur_w   <= WID_W'(1);
            r_cur_h   <= HW'(1);
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_cur_w   <= n_cur_w;
            r_cur_h   <= n_cur_h;
        end
    end

    // line stores, read one column ahead
    assign px = is_flush ? '0 : ebb_pkg::t_pix'{red: i_in_data.red,
                                                green: i_in_data.green,
                                                blue: i_in_data.blue};
    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = px;

    ebb_line_mem #(
        .DEPTH(MAX_WIDTH)
    ) u_line_mem (
        .i_clk    (i_clk),
        .i_wr_en  (do_push),
        .i_wr_addr(r_in_col),
        .i_wr_data(wr_pair),
        .i_rd_addr(n_in_col),
        .o_rd_data(rd_pair)
    );

    // window: chain of three column cells, newest column first
    assign cell_in[0] = '{row0: px, row1: rd_pair.newer, row2: rd_pair.older};
    assign cell_in[1] = cell_out[0];
    assign cell_in[2] = cell_out[1];
    assign cell_use   = {r_s1_nbr.lf, 1'b1, r_s1_nbr.rt};

    for (genvar c = 0; c < 3; c++) begin : g_cell
        ebb_win_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(do_push),
            .i_col  (cell_in[c]),
            .i_use  (cell_use[c]),
            .i_nbr  (r_s1_nbr),
            .o_col  (cell_out[c]),
            .o_sum  (cell_sum[c])
        );
    end

    assign tot_sum.red   = SW'(cell_sum[0].red) + SW'(cell_sum[1].red)
                         + SW'(cell_sum[2].red);
    assign tot_sum.green = SW'(cell_sum[0].green) + SW'(cell_sum[1].green)
                         + SW'(cell_sum[2].green);
    assign tot_sum.blue  = SW'(cell_sum[0].blue) + SW'(cell_sum[1].blue)
                         + SW'(cell_sum[2].blue);

    assign n_rows = 2'd1 + 2'(r_s1_nbr.up) + 2'(r_s1_nbr.dn);
    assign n_cols = 2'd1 + 2'(r_s1_nbr.lf) + 2'(r_s1_nbr.rt);
    assign n_cnt  = NW'(n_rows) * NW'(n_cols);

    ebb_mean u_mean_r (.i_sum(r_s2_sum.red),   .i_n(r_s2_n), .o_mean(mean_r));
    ebb_mean u_mean_g (.i_sum(r_s2_sum.green), .i_n(r_s2_n), .o_mean(mean_g));
    ebb_mean u_mean_b (.i_sum(r_s2_sum.blue),  .i_n(r_s2_n), .o_mean(mean_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= emit;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_take) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_nbr <= nbr_now;
            r_s1_eof <= eof_now;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_sum <= tot_sum;
            r_s2_n   <= n_cnt;
            r_s2_eof <= r_s1_eof;
        end
        if (out_take && r_s2_valid) begin
            r_out_data.blur_red     <= mean_r;
            r_out_data.blur_green   <= mean_g;
            r_out_data.blur_blue    <= mean_b;
            r_out_data.end_of_frame <= r_s2_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_stall_only_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid)
        else $error("input stalled with empty first stage");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WID_W'(r_in_col) < r_cur_w) && (WID_W'(r_out_col) < r_cur_w))
        else $error("column counter beyond frame width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_row <= ROW_W'(r_cur_h) + ROW_W'(1)) && (r_out_row < r_cur_h))
        else $error("row counter beyond frame height");

    a_eof_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && eof_now) |=> (r_in_row == '0) && (r_in_col == '0) && r_s1_eof)
        else $error("frame not closed after last result");
`endif

endmodule
